// ----- src/csdp_pkg.sv -----
`default_nettype none
package csdp_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Accumulator carries four guard bits above the 64-bit magnitude
    localparam int unsigned ACC_W = 68;
    localparam logic [ACC_W-1:0] LIMIT_POS = {4'h0, 64'h7FFF_FFFF_FFFF_FFFF};
    localparam logic [ACC_W-1:0] LIMIT_NEG = {4'h0, 64'h8000_0000_0000_0000};

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;
    localparam int unsigned QCW    = QAW + 1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       plain_style;
        logic       last;
    } t_in;

    typedef struct packed {
        logic              valid_res;
        logic signed [63:0] number;
    } t_out;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MINUS,
        KIND_DIGIT,
        KIND_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       start;
        logic       style_bad;
        logic       last;
    } t_tok;

endpackage
`default_nettype wire

// ----- src/canonical_signed_decimal_parse.sv -----
`default_nettype none
// Canonical signed decimal parser.
// Input channel: one character per transfer (i_in_valid / o_in_stall), with
// has_char, plain_style and last. plain_style counts only on the first
// transfer of a string; an empty string is one last transfer without a char.
// Output channel: one result per string, on its last transfer
// (o_out_valid / i_out_stall): valid_res and the 64-bit two's complement
// number, zero when the text is not a canonical in-range decimal.
// Throughput: one character per cycle while o_in_stall is low; strings may
// follow back to back. A last character passes the token queue, the digit
// step into the finished-string register, then the output conversion. The
// digit step (magnitude*10 + digit with a range compare) runs once per cycle
// in the back end while it pops; a four-entry token queue sits before it.
// Reset clears the queue and all string state; the next transfer starts a new
// string. While the receiver stalls, the result holds, one more finished
// string waits behind it, and characters keep flowing until the queue fills,
// at which point o_in_stall rises.
module canonical_signed_decimal_parse
    import csdp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_tok push_tok;
    t_tok head_tok;

    csdp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_push_tok (push_tok)
    );

    csdp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_tok (push_tok),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_head     (head_tok)
    );

    csdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_tok       (head_tok),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ----- src/csdp_fifo.sv -----
`default_nettype none
module csdp_fifo
    import csdp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_push_tok,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_tok      o_head
);

    t_tok           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_tok;
        end
    end

endmodule
`default_nettype wire

// ----- src/csdp_front.sv -----
`default_nettype none
module csdp_front
    import csdp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in_data,
    input  wire logic i_q_full,
    output logic      o_in_stall,
    output logic      o_push,
    output t_tok      o_push_tok
);

    logic r_at_start, n_at_start;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_push_tok.kind      = KIND_NONE;
        o_push_tok.digit     = i_in_data.char_code[3:0];
        o_push_tok.start     = r_at_start;
        o_push_tok.style_bad = r_at_start && !i_in_data.plain_style;
        o_push_tok.last      = i_in_data.last;
        if (i_in_data.has_char) begin
            if (i_in_data.char_code == CHAR_MINUS) begin
                o_push_tok.kind = KIND_MINUS;
            end else if (i_in_data.char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
                o_push_tok.kind = KIND_DIGIT;
            end else begin
                o_push_tok.kind = KIND_OTHER;
            end
        end
    end

    // A new string begins after every last transfer
    always_comb begin
        n_at_start = r_at_start;
        if (o_push) begin
            n_at_start = i_in_data.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else begin
            r_at_start <= n_at_start;
        end
    end

endmodule
`default_nettype wire

// ----- src/csdp_back.sv -----
`default_nettype none
module csdp_back
    import csdp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_tok i_tok,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    logic        r_neg, n_neg;
    logic        r_seen, n_seen;
    logic        r_lz, n_lz;
    logic        r_fail, n_fail;
    logic [63:0] r_mag, n_mag;

    logic        r_fin_vld;
    logic        r_fin_ok;
    logic        r_fin_neg;
    logic [63:0] r_fin_mag;

    logic        r_out_vld;
    t_out        r_out;

    logic             fin_move;
    logic             fin_free;
    logic             cur_neg, cur_seen, cur_lz, cur_fail;
    logic [63:0]      cur_mag;
    logic [ACC_W-1:0] acc_wide;
    logic [ACC_W-1:0] limit;

    assign fin_move = r_fin_vld && (!r_out_vld || !i_out_stall);
    assign fin_free = !r_fin_vld || fin_move;
    // Non-last tokens produce no result and never wait on the output side
    assign o_pop    = !i_q_empty && (!i_tok.last || fin_free);

    always_comb begin
        cur_neg  = r_neg;
        cur_seen = r_seen;
        cur_lz   = r_lz;
        cur_fail = r_fail;
        cur_mag  = r_mag;
        if (i_tok.start) begin
            cur_neg  = 1'b0;
            cur_seen = 1'b0;
            cur_lz   = 1'b0;
            cur_fail = i_tok.style_bad;
            cur_mag  = '0;
        end
    end

    // magnitude*10 + digit, checked against the limit in wide arithmetic
    assign acc_wide = ({4'h0, cur_mag} << 3) + ({4'h0, cur_mag} << 1)
                    + {{(ACC_W - 4){1'b0}}, i_tok.digit};
    assign limit    = cur_neg ? LIMIT_NEG : LIMIT_POS;

    always_comb begin
        n_neg  = cur_neg;
        n_seen = cur_seen;
        n_lz   = cur_lz;
        n_fail = cur_fail;
        n_mag  = cur_mag;
        if (!cur_fail) begin
            case (i_tok.kind)
                KIND_MINUS: begin
                    if (cur_neg || cur_seen) begin
                        n_fail = 1'b1;
                    end else begin
                        n_neg = 1'b1;
                    end
                end
                KIND_DIGIT: begin
                    if (cur_lz || (acc_wide > limit)) begin
                        n_fail = 1'b1;
                    end else begin
                        n_lz   = !cur_seen && (i_tok.digit == 4'd0);
                        n_mag  = acc_wide[63:0];
                        n_seen = 1'b1;
                    end
                end
                KIND_OTHER: begin
                    n_fail = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg  <= 1'b0;
            r_seen <= 1'b0;
            r_lz   <= 1'b0;
            r_fail <= 1'b0;
        end else if (o_pop) begin
            r_neg  <= n_neg;
            r_seen <= n_seen;
            r_lz   <= n_lz;
            r_fail <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mag <= n_mag;
        end
    end

    // Hold the finished string until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (o_pop && i_tok.last) begin
            r_fin_vld <= 1'b1;
        end else if (fin_move) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_tok.last) begin
            r_fin_ok  <= !n_fail && n_seen;
            r_fin_neg <= n_neg;
            r_fin_mag <= n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_move) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            r_out.valid_res <= r_fin_ok;
            if (!r_fin_ok) begin
                r_out.number <= '0;
            end else if (r_fin_neg) begin
                r_out.number <= -$signed(r_fin_mag);
            end else begin
                r_out.number <= $signed(r_fin_mag);
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- tb/sv/decimal_parse_checker.sv -----
`timescale 1ns / 1ps

module decimal_parse_checker
    import csdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [63:0] POS_MAX = LIMIT_POS[63:0];
    localparam logic [63:0] NEG_MAG = LIMIT_NEG[63:0];

    // Parser state, mirrored from the block's behavior
    logic        at_start   = 1'b1;
    logic        neg_sign   = 1'b0;
    logic        seen_digit = 1'b0;
    logic        lead_zero  = 1'b0;
    logic        rejected   = 1'b0;
    logic [63:0] magnitude  = '0;

    t_out expected_results[$];
    int   failure_count = 0;

    initial o_pending = 0;
    assign o_fail_count = failure_count;

    function automatic void note_failure(input string msg);
        failure_count++;
        if (failure_count <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    task automatic take_char(input logic [7:0] code);
        logic [63:0] digit;
        logic [63:0] bound;
        if (rejected)
            return;
        if (code == CHAR_MINUS) begin
            if (neg_sign || seen_digit)
                rejected = 1'b1;
            else
                neg_sign = 1'b1;
            return;
        end
        if (code < CHAR_ZERO || code > CHAR_NINE) begin
            rejected = 1'b1;
            return;
        end
        digit = 64'(code - CHAR_ZERO);
        bound = neg_sign ? NEG_MAG : POS_MAX;
        if (lead_zero) begin
            rejected = 1'b1;
            return;
        end
        if (!seen_digit && digit == 0)
            lead_zero = 1'b1;
        // reject before the multiply-add would pass the signed range
        if (magnitude > (bound - digit) / 10) begin
            rejected = 1'b1;
            return;
        end
        magnitude  = magnitude * 10 + digit;
        seen_digit = 1'b1;
    endtask

    task automatic step_parser(input t_in item);
        t_out res;
        if (at_start) begin
            at_start   = 1'b0;
            neg_sign   = 1'b0;
            seen_digit = 1'b0;
            lead_zero  = 1'b0;
            magnitude  = '0;
            rejected   = !item.plain_style;
        end
        if (item.has_char)
            take_char(item.char_code);
        if (item.last) begin
            res.valid_res = !rejected && seen_digit;
            res.number    = '0;
            if (res.valid_res)
                res.number = neg_sign ? -magnitude : magnitude;
            expected_results.insert(expected_results.size(), res);
            at_start = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            at_start = 1'b1;
            neg_sign = 1'b0;
            seen_digit = 1'b0;
            lead_zero = 1'b0;
            rejected = 1'b0;
            magnitude = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result valid_res=%0b number=%0d",
                        i_out_data.valid_res, i_out_data.number));
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.valid_res !== want.valid_res
                            || i_out_data.number !== want.number)
                        note_failure($sformatf(
                            "expected valid_res=%0b number=%0d, got valid_res=%0b number=%0d",
                            want.valid_res, want.number,
                            i_out_data.valid_res, i_out_data.number));
                end
            end
            if (i_in_valid && !i_in_stall)
                step_parser(i_in_data);
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import csdp_pkg::*;

    localparam logic [63:0] POS_MAX = LIMIT_POS[63:0];
    localparam logic [63:0] NEG_MAG = LIMIT_NEG[63:0];
    localparam int PHASE_ITEMS = 180;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;
    int   fail_count;
    int   pending;

    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;

    // characters of the string being built
    logic [7:0] text[$];

    always #5 clk = ~clk;

    canonical_signed_decimal_parse u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    decimal_parse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input logic [7:0] code, input logic has, input logic plain,
                             input logic fin);
        t_in item;
        item.char_code   = code;
        item.has_char    = has;
        item.plain_style = plain;
        item.last        = fin;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // plain_style counts only on the first transfer; later ones carry noise
    task automatic send_text(input logic plain, input int nochar_pct, input logic tail_nochar);
        int n;
        logic first;
        n = text.size();
        first = 1'b1;
        if (n == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, plain, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < nochar_pct) begin
                send_item(8'($urandom_range(255)), 1'b0,
                          first ? plain : 1'($urandom_range(1)), 1'b0);
                first = 1'b0;
            end
            send_item(text[i], 1'b1, first ? plain : 1'($urandom_range(1)),
                      (i == n - 1) && !tail_nochar);
            first = 1'b0;
        end
        if (tail_nochar)
            send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.insert(text.size(), s[i]);
    endtask

    task automatic run_case(input string s, input logic plain);
        load_text(s);
        send_text(plain, 0, 1'b0);
    endtask

    task automatic push_decimal(input logic [63:0] value);
        logic [7:0]  rev[$];
        logic [63:0] rest;
        rest = value;
        do begin
            rev.insert(rev.size(), CHAR_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        while (rev.size() != 0)
            text.insert(text.size(), rev.pop_back());
    endtask

    task automatic build_random_text(output logic plain);
        int          kind;
        int          pos;
        logic        neg;
        logic [63:0] mag;
        kind  = $urandom_range(99);
        plain = 1'b1;
        text.delete();
        if (kind < 82) begin
            neg = 1'($urandom_range(1));
            case ($urandom_range(4))
                0, 1: mag = 64'($urandom_range(9999));
                2, 3: mag = {$urandom, $urandom} >> $urandom_range(63);
                // straddle the range limit
                default: mag = (neg ? NEG_MAG : POS_MAX) + 64'($urandom_range(6)) - 64'd3;
            endcase
            if (neg)
                text.insert(text.size(), CHAR_MINUS);
            push_decimal(mag);
            if (kind >= 60 && kind < 68) begin
                plain = 1'b0;
            end else if (kind >= 68) begin
                pos = $urandom_range(text.size() - 1);
                case ($urandom_range(4))
                    0: text[pos] = 8'($urandom_range(255));
                    1: text.insert(pos, CHAR_MINUS);
                    2: text.insert(neg ? 1 : 0, CHAR_ZERO);
                    3: text.insert(text.size(), CHAR_MINUS);
                    default: repeat ($urandom_range(1, 3))
                        text.insert(text.size(), CHAR_ZERO + 8'($urandom_range(9)));
                endcase
            end
        end else if (kind < 92) begin
            repeat ($urandom_range(6))
                text.insert(text.size(), 8'($urandom_range(255)));
            plain = 1'($urandom_range(1));
        end else begin
            case ($urandom_range(3))
                0: load_text("-");
                1: load_text("");
                2: load_text("-0");
                default: load_text("00");
            endcase
        end
    endtask

    initial begin
        logic plain;
        int   target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_case("0", 1'b1);
        run_case("-0", 1'b1);
        run_case("9223372036854775807", 1'b1);
        run_case("-9223372036854775808", 1'b1);
        run_case("9223372036854775808", 1'b1);
        run_case("-9223372036854775809", 1'b1);
        run_case("01", 1'b1);
        run_case("-", 1'b1);
        run_case("--1", 1'b1);
        run_case("1-", 1'b1);
        run_case("1/", 1'b1);
        run_case(":", 1'b1);
        run_case("5", 1'b0);
        run_case("", 1'b1);
        // characters interleaved with empty transfers, then an empty last
        load_text("42");
        send_text(1'b1, 100, 1'b0);
        load_text("7");
        send_text(1'b1, 0, 1'b1);
        text.delete();
        text.insert(text.size(), 8'hFF);
        text.insert(text.size(), 8'h00);
        send_text(1'b1, 0, 1'b0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 46; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 46; end
                default: begin idle_pct = 35; stall_pct <= 35; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                build_random_text(plain);
                send_text(plain, 5, $urandom_range(99) < 5);
            end
        end

        in_valid  <= 1'b0;
        stall_pct <= 0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
